// ----- design/vsa_pkg.sv -----
package vsa_pkg;

  // request and result field widths
  localparam int SLOT_IDX_W = 6;
  localparam int STATUS_W   = 2;

  // busy bits examined per scan cycle
  localparam int CHUNK    = 8;
  localparam int CHUNK_W  = 3;

  // request codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FULL      = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_NOT_BUSY  = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic post;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_release;
    logic hit;
    logic last_grp;
  } dp_sts_t;

endpackage

// ----- design/vsa_ctrl.sv -----
module vsa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  vsa_pkg::dp_sts_t    sts,
  output vsa_pkg::ctrl_cmd_t  cmd
);
  import vsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_POST = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   post_fire;

  // handshake decode
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign post_fire = (state_r == S_POST) && (!out_valid_r || out_ready);

  assign cmd.load = (state_r == S_IDLE) && in_valid;
  assign cmd.step = (state_r == S_SCAN);
  assign cmd.post = post_fire;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.is_release ? S_POST : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit || sts.last_grp) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (post_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register valid flag
  always_comb begin
    if (post_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/vsa_dp.sv -----
module vsa_dp #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  vsa_pkg::ctrl_cmd_t                   cmd,
  output vsa_pkg::dp_sts_t                     sts,
  input  logic                                 in_cmd,
  input  logic [vsa_pkg::SLOT_IDX_W-1:0]       in_slot_index,
  output logic [vsa_pkg::STATUS_W-1:0]         out_status,
  output logic [vsa_pkg::SLOT_IDX_W-1:0]       out_granted_slot
);
  import vsa_pkg::*;

  localparam int IDX_W  = $clog2(SLOT_COUNT);
  localparam int GROUPS = (SLOT_COUNT + CHUNK - 1) / CHUNK;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int PAD_W  = GRP_W + CHUNK_W;
  localparam int PAD    = GROUPS * CHUNK;

  // busy bit of each slot
  logic [SLOT_COUNT-1:0] busy_r, busy_nxt;
  logic [IDX_W-1:0]      start_r, start_nxt;

  // request and scan registers
  logic                  rel_r;
  logic                  req_ok_r;
  logic [PAD_W-1:0]      req_pad_r;
  logic [GRP_W-1:0]      grp_r, grp_nxt;
  logic                  first_r, first_nxt;
  logic                  last_r, last_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      found_idx_r, found_idx_nxt;

  logic [STATUS_W-1:0]   status_r;
  logic [SLOT_IDX_W-1:0] grant_r;

  logic [PAD-1:0]        busy_pad;
  logic [CHUNK-1:0]      grp_word;
  logic [PAD_W-1:0]      start_ext;
  logic [PAD_W-1:0]      in_pad;
  logic [GRP_W-1:0]      start_grp;
  logic [CHUNK_W-1:0]    start_bit;
  logic [CHUNK-1:0]      ge_mask;
  logic [CHUNK-1:0]      scan_mask;
  logic [CHUNK-1:0]      free_bits;
  logic                  hit;
  logic [CHUNK_W-1:0]    hit_bit;
  logic [GRP_W-1:0]      grp_inc;
  logic                  rel_busy;
  status_t               status_nxt;

  // group of busy bits at the scan pointer, missing slots read busy
  always_comb begin
    busy_pad                   = '1;
    busy_pad[SLOT_COUNT-1:0]   = busy_r;
  end
  assign grp_word = busy_pad[{grp_r, CHUNK_W'(0)} +: CHUNK];

  assign start_ext = PAD_W'(start_r);
  assign start_grp = start_ext[PAD_W-1:CHUNK_W];
  assign start_bit = start_ext[CHUNK_W-1:0];
  assign in_pad    = PAD_W'(in_slot_index);

  // window within the group: from start on first visit, below start on last
  always_comb begin
    for (int i = 0; i < CHUNK; i++) begin
      ge_mask[i] = (CHUNK_W'(i) >= start_bit);
    end
    if (first_r) begin
      scan_mask = ge_mask;
    end else if (last_r) begin
      scan_mask = ~ge_mask;
    end else begin
      scan_mask = '1;
    end
  end

  // lowest free slot in the window
  assign free_bits = ~grp_word & scan_mask;
  assign hit       = |free_bits;
  always_comb begin
    hit_bit = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_bit = CHUNK_W'(i);
      end
    end
  end

  assign grp_inc  = (grp_r == GRP_W'(GROUPS - 1)) ? '0 : grp_r + GRP_W'(1);
  assign rel_busy = req_ok_r && grp_word[req_pad_r[CHUNK_W-1:0]];

  assign sts.is_release = (in_cmd == CMD_RELEASE);
  assign sts.hit        = hit;
  assign sts.last_grp   = last_r;

  // scan pointer and search result
  always_comb begin
    grp_nxt       = grp_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    if (cmd.load) begin
      grp_nxt   = (in_cmd == CMD_RELEASE) ? in_pad[PAD_W-1:CHUNK_W] : start_grp;
      first_nxt = 1'b1;
      last_nxt  = 1'b0;
      found_nxt = 1'b0;
    end else if (cmd.step) begin
      if (hit) begin
        found_nxt     = 1'b1;
        found_idx_nxt = IDX_W'({grp_r, hit_bit});
      end else begin
        grp_nxt   = grp_inc;
        first_nxt = 1'b0;
        last_nxt  = (grp_inc == start_grp);
      end
    end
  end

  // commit of the request once its result is posted
  always_comb begin
    busy_nxt   = busy_r;
    start_nxt  = start_r;
    status_nxt = ST_NOT_BUSY;
    if (rel_r == CMD_RELEASE) begin
      if (rel_busy) begin
        status_nxt = ST_RELEASED;
      end
    end else begin
      status_nxt = found_r ? ST_ALLOCATED : ST_FULL;
    end
    if (cmd.post) begin
      if (rel_r == CMD_RELEASE) begin
        if (rel_busy) begin
          busy_nxt[IDX_W'(req_pad_r)] = 1'b0;
        end
      end else begin
        start_nxt = (start_r == IDX_W'(SLOT_COUNT - 1)) ? '0 : start_r + IDX_W'(1);
        if (found_r) begin
          busy_nxt[found_idx_r] = 1'b1;
        end
      end
    end
  end

  // pool state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= '0;
      start_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      start_r <= start_nxt;
    end
  end

  // request capture, scan state and output payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rel_r     <= in_cmd;
      req_ok_r  <= (int'(in_slot_index) < SLOT_COUNT);
      req_pad_r <= in_pad;
    end
    grp_r       <= grp_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    found_r     <= found_nxt;
    found_idx_r <= found_idx_nxt;
    if (cmd.post) begin
      status_r <= status_nxt;
      grant_r  <= (status_nxt == ST_ALLOCATED) ? SLOT_IDX_W'(found_idx_r) : '0;
    end
  end

  assign out_status       = status_r;
  assign out_granted_slot = grant_r;

endmodule

// ----- design/versioned_slot_allocator_unit.sv -----
// Versioned slot allocator: a pool of SLOT_COUNT slots, each free or busy.
// Input channel (in_valid/in_ready): in_cmd selects allocate (0) or release
// (1); in_slot_index names the slot to release and is ignored on allocate.
// Result channel (out_valid/out_ready): one result per request, out_status
// (allocated, pool full, released, release of a free slot) and
// out_granted_slot, which is zero unless a slot was allocated.
// An allocate starts its search at a rotating pointer that advances on
// every allocate, and takes the first free slot from there with wraparound.
// A release goes from acceptance straight to the result post; an allocate
// first runs the group scan, which examines 8 busy bits per cycle and
// ends on a hit or after revisiting the start group below the pointer.
// One request is handled at a time; in_ready rises again in the cycle after
// the result is posted.
// The result sits in an output register: while the receiver stalls, the next
// request is still accepted and searched, and it posts once the register
// drains. Reset (synchronous, active low) marks every slot free, sets the
// search pointer to slot 0 and empties the output register.
module versioned_slot_allocator_unit #(
  parameter int SLOT_COUNT = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [vsa_pkg::SLOT_IDX_W-1:0] in_slot_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vsa_pkg::STATUS_W-1:0]   out_status,
  output logic [vsa_pkg::SLOT_IDX_W-1:0] out_granted_slot
);
  import vsa_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer
  vsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // busy bits, search pointer and result register
  vsa_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_cmd           (in_cmd),
    .in_slot_index    (in_slot_index),
    .out_status       (out_status),
    .out_granted_slot (out_granted_slot)
  );

endmodule

// ----- design/vsa_checker.sv -----
module vsa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [vsa_pkg::STATUS_W-1:0]   out_status,
  input logic [vsa_pkg::SLOT_IDX_W-1:0] out_granted_slot
);
  import vsa_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_granted_slot))
    else $error("stalled result changed");

  // grant is zero unless a slot was allocated
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ALLOCATED) |-> out_granted_slot == '0)
    else $error("nonzero grant without allocation");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one in flight");

  // no result in the cycle right after acceptance
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result posted too early");

endmodule

bind versioned_slot_allocator_unit vsa_checker u_vsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_granted_slot (out_granted_slot)
);

// ----- tb/versioned_slot_allocator_unit_tb.sv -----
module versioned_slot_allocator_unit_tb;
  import vsa_pkg::*;

  localparam int POOL_SLOTS   = 64;
  localparam int VER_W        = 32;
  localparam int TOTAL_ITEMS  = 1900;
  localparam int TAIL_CYCLES  = 16;
  localparam int RESET_CYCLES = 8;
  localparam int DIR_ROWS     = 21;

  typedef struct packed {
    status_t               status;
    logic [SLOT_IDX_W-1:0] slot;
  } pool_resp_t;

  // one directed request; typed rows carry their own expected response
  typedef struct packed {
    logic                  cmd;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  typed;
    status_t               status;
    logic [SLOT_IDX_W-1:0] slot;
  } stim_row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} traffic_phase_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_cmd = CMD_ALLOC;
  logic [SLOT_IDX_W-1:0] in_slot_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [SLOT_IDX_W-1:0] out_granted_slot;

  // shadow of the pool: versions and rotating search pointer
  logic [VER_W-1:0]      slot_ver [POOL_SLOTS];
  int                    scan_ptr;

  pool_resp_t            pending_responses [$];
  int                    mismatches = 0;
  int                    burst_left = 0;

  // directed requests, walked in order right after reset
  stim_row_t directed_rows [DIR_ROWS] = '{
    '{CMD_ALLOC,   6'd0,  1'b1, ST_ALLOCATED, 6'd0},
    '{CMD_ALLOC,   6'd63, 1'b1, ST_ALLOCATED, 6'd1},
    '{CMD_RELEASE, 6'd0,  1'b1, ST_RELEASED,  6'd0},
    '{CMD_RELEASE, 6'd0,  1'b1, ST_NOT_BUSY,  6'd0},
    '{CMD_RELEASE, 6'd63, 1'b1, ST_NOT_BUSY,  6'd0},
    '{CMD_RELEASE, 6'd1,  1'b1, ST_RELEASED,  6'd0},
    '{CMD_ALLOC,   6'd0,  1'b1, ST_ALLOCATED, 6'd2},
    '{CMD_ALLOC,   6'd0,  1'b1, ST_ALLOCATED, 6'd3},
    '{CMD_RELEASE, 6'd2,  1'b1, ST_RELEASED,  6'd0},
    '{CMD_RELEASE, 6'd3,  1'b1, ST_RELEASED,  6'd0},
    '{CMD_RELEASE, 6'd1,  1'b1, ST_NOT_BUSY,  6'd0},
    '{CMD_ALLOC,   6'd21, 1'b0, ST_ALLOCATED, 6'd0},
    '{CMD_ALLOC,   6'd42, 1'b0, ST_ALLOCATED, 6'd0},
    '{CMD_ALLOC,   6'd0,  1'b0, ST_ALLOCATED, 6'd0},
    '{CMD_RELEASE, 6'd5,  1'b0, ST_ALLOCATED, 6'd0},
    '{CMD_RELEASE, 6'd4,  1'b0, ST_ALLOCATED, 6'd0},
    '{CMD_RELEASE, 6'd6,  1'b0, ST_ALLOCATED, 6'd0},
    '{CMD_RELEASE, 6'd7,  1'b0, ST_ALLOCATED, 6'd0},
    '{CMD_ALLOC,   6'd63, 1'b0, ST_ALLOCATED, 6'd0},
    '{CMD_ALLOC,   6'd0,  1'b0, ST_ALLOCATED, 6'd0},
    '{CMD_RELEASE, 6'd32, 1'b0, ST_ALLOCATED, 6'd0}
  };

  versioned_slot_allocator_unit #(
    .SLOT_COUNT(POOL_SLOTS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_slot_index   (in_slot_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_granted_slot(out_granted_slot)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // advance the pool shadow by one request and return its response
  task automatic apply_request(input logic cmd, input logic [SLOT_IDX_W-1:0] idx,
                               output pool_resp_t resp);
    int  start;
    int  probe;
    int  k;
    bit  found;
    start = scan_ptr;
    found = 1'b0;
    resp.slot = '0;
    if (cmd == CMD_ALLOC) begin
      // pointer moves on even when the pool turns out full
      scan_ptr = (scan_ptr + 1) % POOL_SLOTS;
      for (k = 0; k < POOL_SLOTS && !found; k++) begin
        probe = (start + k) % POOL_SLOTS;
        if (!slot_ver[probe][0]) begin
          slot_ver[probe] = slot_ver[probe] + 1'b1;
          resp.slot = probe[SLOT_IDX_W-1:0];
          found = 1'b1;
        end
      end
      resp.status = found ? ST_ALLOCATED : ST_FULL;
    end else if (int'(idx) < POOL_SLOTS && slot_ver[idx][0]) begin
      slot_ver[idx] = slot_ver[idx] + 1'b1;
      resp.status = ST_RELEASED;
    end else begin
      resp.status = ST_NOT_BUSY;
    end
  endtask

  // random busy slot, or a random index when nothing is busy
  function automatic logic [SLOT_IDX_W-1:0] pick_release_slot();
    int start;
    int k;
    int probe;
    start = $urandom_range(0, POOL_SLOTS - 1);
    for (k = 0; k < POOL_SLOTS; k++) begin
      probe = (start + k) % POOL_SLOTS;
      if (slot_ver[probe][0]) return probe[SLOT_IDX_W-1:0];
    end
    return start[SLOT_IDX_W-1:0];
  endfunction

  // drive one request in bursts with random gaps, then record its response
  task automatic send_request(input logic cmd, input logic [SLOT_IDX_W-1:0] idx,
                              input logic typed, input pool_resp_t typed_resp);
    pool_resp_t predicted;
    int         gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_cmd = cmd;
    in_slot_index = idx;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_request(cmd, idx, predicted);
    pending_responses.push_back(typed ? typed_resp : predicted);
    burst_left--;
    @(negedge clk);
  endtask

  // receiver ready pattern: open stretches, coin flips and long stalls
  rx_mode_e rx_mode = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;
  logic     hold_ready = 1'b0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (rx_mode)
      RX_OPEN: begin
        out_ready = 1'b1;
      end
      RX_COIN: begin
        out_ready = 1'($urandom_range(0, 1));
      end
      default: begin
        if (hold_left == 0) begin
          hold_ready = !hold_ready;
          hold_left = hold_ready ? $urandom_range(1, 4) : $urandom_range(1, 20);
        end
        hold_left--;
        out_ready = hold_ready;
      end
    endcase
  end

  // response checker
  always @(posedge clk) begin
    pool_resp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: status %0d slot %0d", out_status, out_granted_slot);
      end else begin
        want = pending_responses.pop_front();
        if (out_status !== want.status || out_granted_slot !== want.slot) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                     want.status, want.slot, out_status, out_granted_slot);
        end
      end
    end
  end

  // stimulus
  initial begin
    traffic_phase_e phase;
    int             sent;
    int             plen;
    int             roll;
    int             i;
    pool_resp_t     typed_resp;
    for (i = 0; i < POOL_SLOTS; i++) slot_ver[i] = VER_W'(2 * i);
    scan_ptr = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table
    for (i = 0; i < DIR_ROWS; i++) begin
      typed_resp.status = directed_rows[i].status;
      typed_resp.slot = directed_rows[i].slot;
      send_request(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].typed,
                   typed_resp);
    end
    sent = DIR_ROWS;

    // random traffic in phases: fill up to full, drain, mixed
    typed_resp = '0;
    while (sent < TOTAL_ITEMS) begin
      phase = traffic_phase_e'($urandom_range(0, 2));
      plen = $urandom_range(20, 100);
      repeat (plen) begin
        roll = $urandom_range(0, 99);
        case (phase)
          PH_FILL: begin
            if (roll < 92)
              send_request(CMD_ALLOC, SLOT_IDX_W'($urandom_range(0, 63)), 1'b0, typed_resp);
            else
              send_request(CMD_RELEASE, pick_release_slot(), 1'b0, typed_resp);
          end
          PH_DRAIN: begin
            if (roll < 80)
              send_request(CMD_RELEASE, pick_release_slot(), 1'b0, typed_resp);
            else if (roll < 90)
              send_request(CMD_RELEASE, SLOT_IDX_W'($urandom_range(0, 63)), 1'b0,
                           typed_resp);
            else
              send_request(CMD_ALLOC, SLOT_IDX_W'($urandom_range(0, 63)), 1'b0, typed_resp);
          end
          default: begin
            if (roll < 50)
              send_request(CMD_ALLOC, SLOT_IDX_W'($urandom_range(0, 63)), 1'b0, typed_resp);
            else if (roll < 75)
              send_request(CMD_RELEASE, pick_release_slot(), 1'b0, typed_resp);
            else
              send_request(CMD_RELEASE, SLOT_IDX_W'($urandom_range(0, 63)), 1'b0,
                           typed_resp);
          end
        endcase
      end
      sent += plen;
    end
    in_valid = 1'b0;

    // drain outstanding responses, then a short tail
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
